// File: sv/kwa_pkg.sv
package kwa_pkg;

   // Fixed field widths.
   localparam int POS_W       = 16;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int CNT_OUT_W   = 10;
   localparam int WIN_W       = 8;
   localparam int MAXPT_W     = 10;
   localparam int IMG_W       = 11;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 11;

   // Parameter defaults.
   localparam int TABLE_DEPTH_DEF   = 512;
   localparam int FRACTION_BITS_DEF = 4;

   // Register reset values.
   localparam logic [WIN_W-1:0]   WINDOW_WIDTH_RST  = 8'd20;
   localparam logic [WIN_W-1:0]   WINDOW_HEIGHT_RST = 8'd20;
   localparam logic [MAXPT_W-1:0] MAX_POINTS_RST    = 10'd500;
   localparam logic [IMG_W-1:0]   IMAGE_WIDTH_RST   = 11'd640;
   localparam logic [IMG_W-1:0]   IMAGE_HEIGHT_RST  = 11'd480;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POINTS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd4;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_END   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_OFFER = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_STORED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd3;

   typedef struct packed {
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] x;
   } point_type;

   // Shift controls shared by every cell of the ring.
   typedef struct packed {
      logic push;
      logic rotate;
   } cell_ctl_type;

endpackage

// File: sv/keypoint_window_admission.sv
// An item is taken only while the block is idle, not before the last result is registered.
// Clear, load, end of tracking and candidates that need no window test give their result
// from the execute state. A candidate checked against a non-empty table goes through the
// scan and finish states, as the ring rotates one cell per cycle past one window comparator.
// Reset empties the table (count and keyframe count zero, table flagged empty) and loads
// the register defaults; the point cells themselves are not cleared.
module keypoint_window_admission
   import kwa_pkg::*;
#(
   parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic                  req_track_ok,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_keyframe,
   output logic [CNT_OUT_W-1:0]  rsp_point_count,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CW     = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int MW     = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
   localparam int KW     = CW + 3;
   localparam int LIM_IW = IMG_W + FRACTION_BITS;
   localparam int LIM_W  = (LIM_IW > POS_W) ? LIM_IW : POS_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]               state_ff;
   logic [1:0]               state_in;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic [CW-1:0]            last_key_ff;
   logic [CW-1:0]            last_key_in;
   logic                     empty_ff;
   logic                     empty_in;
   logic [IDX_W-1:0]         scan_ff;
   logic [IDX_W-1:0]         scan_in;

   logic [WIN_W-1:0]         win_w_ff;
   logic [WIN_W-1:0]         win_h_ff;
   logic [MAXPT_W-1:0]       max_points_ff;
   logic [IMG_W-1:0]         img_w_ff;
   logic [IMG_W-1:0]         img_h_ff;

   logic [FUNC_W-1:0]        item_func_ff;
   logic                     item_ok_ff;
   logic signed [POS_W-1:0]  item_x_ff;
   logic signed [POS_W-1:0]  item_y_ff;

   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic                     rsp_keyframe_ff;
   logic [CNT_OUT_W-1:0]     rsp_point_count_ff;

   logic                     out_free;
   logic                     done;
   logic                     emit;
   logic                     store;
   logic                     start_scan;
   logic                     res_key;
   logic [STATUS_W-1:0]      res_status;
   logic                     room;
   logic                     over_limit;
   logic                     in_image;
   logic                     scan_valid;
   logic                     hit;
   logic [MW-1:0]            count_ext;
   logic [MW-1:0]            max_ext;
   logic [MW-1:0]            count_in_ext;
   logic [LIM_W-1:0]         x_lim;
   logic [LIM_W-1:0]         y_lim;
   logic [CW-1:0]            diff;
   logic [KW-1:0]            five_diff;
   logic                     key_hit;

   cell_ctl_type             cell_ctl;
   point_type                new_point;
   point_type                cell_point [TABLE_DEPTH];
   point_type                prev_src   [TABLE_DEPTH];
   point_type                next_src   [TABLE_DEPTH];

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign new_point = {item_y_ff, item_x_ff};

   always_comb begin
      count_ext  = MW'(count_ff);
      max_ext    = MW'(max_points_ff);
      room       = count_ff < CW'(TABLE_DEPTH);
      over_limit = (count_ext >= max_ext) || !room;
      x_lim      = LIM_W'(img_w_ff) << FRACTION_BITS;
      y_lim      = LIM_W'(img_h_ff) << FRACTION_BITS;
      in_image   = !item_x_ff[POS_W-1] && !item_y_ff[POS_W-1] &&
                   (LIM_W'($unsigned(item_x_ff)) < x_lim) &&
                   (LIM_W'($unsigned(item_y_ff)) < y_lim);
      diff       = (count_ff > last_key_ff) ? (count_ff - last_key_ff)
                                            : (last_key_ff - count_ff);
      five_diff  = KW'({diff, 2'b00}) + KW'(diff);
      key_hit    = five_diff >= KW'(last_key_ff);
      scan_valid = CW'(scan_ff) < count_ff;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      last_key_in = last_key_ff;
      empty_in    = empty_ff;
      scan_in     = scan_ff;
      done        = 1'b0;
      store       = 1'b0;
      start_scan  = 1'b0;
      res_key     = 1'b0;
      res_status  = STATUS_NONE;
      cell_ctl    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (item_func_ff)
               FUNC_CLEAR: begin
                  done     = 1'b1;
                  count_in = '0;
                  empty_in = 1'b1;
               end
               FUNC_LOAD: begin
                  done = 1'b1;
                  if (item_ok_ff && in_image) begin
                     if (room) begin
                        store      = 1'b1;
                        res_status = STATUS_STORED;
                     end else begin
                        res_status = STATUS_DROPPED;
                     end
                  end
               end
               FUNC_END: begin
                  done     = 1'b1;
                  empty_in = (count_ff == '0);
                  if (key_hit) begin
                     res_key     = 1'b1;
                     last_key_in = count_ff;
                  end
               end
               FUNC_OFFER: begin
                  if (empty_ff) begin
                     done = 1'b1;
                     if (room) begin
                        store      = 1'b1;
                        res_status = STATUS_STORED;
                     end else begin
                        res_status = STATUS_DROPPED;
                     end
                  end else if (over_limit) begin
                     done       = 1'b1;
                     res_status = STATUS_DROPPED;
                  end else begin
                     start_scan = 1'b1;
                     scan_in    = '0;
                     state_in   = ST_SCAN;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         ST_SCAN: begin
            cell_ctl.rotate = 1'b1;
            scan_in         = scan_ff + IDX_W'(1);
            if (scan_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            done = 1'b1;
            if (hit) begin
               res_status = STATUS_REJECTED;
            end else begin
               store      = 1'b1;
               res_status = STATUS_STORED;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (store) begin
         count_in = count_ff + CW'(1);
      end
      // A finished item waits here until the result register is free.
      emit = done && out_free;
      if (done) begin
         state_in = out_free ? ST_IDLE : state_ff;
      end
      cell_ctl.push = emit && store;
      count_in_ext  = MW'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         last_key_ff   <= '0;
         empty_ff      <= 1'b1;
         scan_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         win_w_ff      <= WINDOW_WIDTH_RST;
         win_h_ff      <= WINDOW_HEIGHT_RST;
         max_points_ff <= MAX_POINTS_RST;
         img_w_ff      <= IMAGE_WIDTH_RST;
         img_h_ff      <= IMAGE_HEIGHT_RST;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         if (emit) begin
            count_ff    <= count_in;
            last_key_ff <= last_key_in;
            empty_ff    <= empty_in;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_WINDOW_WIDTH:  win_w_ff      <= csr_data[WIN_W-1:0];
               CSR_WINDOW_HEIGHT: win_h_ff      <= csr_data[WIN_W-1:0];
               CSR_MAX_POINTS:    max_points_ff <= csr_data[MAXPT_W-1:0];
               CSR_IMAGE_WIDTH:   img_w_ff      <= csr_data[IMG_W-1:0];
               CSR_IMAGE_HEIGHT:  img_h_ff      <= csr_data[IMG_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_func_ff <= req_func;
         item_ok_ff   <= req_track_ok;
         item_x_ff    <= req_pos_x;
         item_y_ff    <= req_pos_y;
      end
      if (emit) begin
         rsp_status_ff      <= res_status;
         rsp_keyframe_ff    <= res_key;
         rsp_point_count_ff <= count_in_ext[CNT_OUT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_keyframe    = rsp_keyframe_ff;
   assign rsp_point_count = rsp_point_count_ff;

   // Stored points sit in cells 0 to count-1; a new point enters at cell 0.
   // One full revolution of the ring brings every point past cell 0 and
   // leaves the ring as it was.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_src[i] = new_point;
      end else begin : g_inner_prev
         assign prev_src[i] = cell_point[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign next_src[i] = cell_point[0];
      end else begin : g_inner_next
         assign next_src[i] = cell_point[i+1];
      end
      kwa_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .prev_point (prev_src[i]),
         .next_point (next_src[i]),
         .point      (cell_point[i])
      );
   end

   kwa_window_check #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_window_check (
      .clock         (clock),
      .reset         (reset),
      .clear         (start_scan),
      .step          (cell_ctl.rotate && scan_valid),
      .stored        (cell_point[0]),
      .candidate     (new_point),
      .window_width  (win_w_ff),
      .window_height (win_h_ff),
      .hit           (hit)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("point count exceeds the table depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cell_ctl.push |=> count_ff == $past(count_ff) + CW'(1))
      else $error("a stored point did not advance the count");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_ff == IDX_W'(TABLE_DEPTH - 1)) |=>
         state_ff == ST_FINISH)
      else $error("scan did not finish after one full revolution");

   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> count_ff != '0)
      else $error("table flagged non-empty with no points");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC || state_ff == ST_FINISH))
      else $error("result raised outside an executing state");

endmodule

// File: sv/kwa_cell.sv
module kwa_cell
   import kwa_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  point_type    prev_point,
   input  point_type    next_point,
   output point_type    point
);

   point_type point_ff;

   // A push moves every point one cell outward, a rotate moves it one cell back.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         point_ff <= prev_point;
      end else if (ctl.rotate) begin
         point_ff <= next_point;
      end
   end

   assign point = point_ff;

endmodule

// File: sv/kwa_window_check.sv
module kwa_window_check
   import kwa_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             step,
   input  point_type        stored,
   input  point_type        candidate,
   input  logic [WIN_W-1:0] window_width,
   input  logic [WIN_W-1:0] window_height,
   output logic             hit
);

   localparam int HALF_W = WIN_W - 1 + FRACTION_BITS;
   localparam int CMP_W  = ((HALF_W > POS_W) ? HALF_W : POS_W) + 2;

   logic signed [CMP_W-1:0] half_x;
   logic signed [CMP_W-1:0] half_y;
   logic signed [CMP_W-1:0] sx;
   logic signed [CMP_W-1:0] sy;
   logic signed [CMP_W-1:0] px;
   logic signed [CMP_W-1:0] py;
   logic                    in_window;
   logic                    hit_ff;
   logic                    hit_in;

   always_comb begin
      half_x = $signed(CMP_W'(window_width >> 1) << FRACTION_BITS);
      half_y = $signed(CMP_W'(window_height >> 1) << FRACTION_BITS);
      sx     = CMP_W'(stored.x);
      sy     = CMP_W'(stored.y);
      px     = CMP_W'(candidate.x);
      py     = CMP_W'(candidate.y);
      // The window is inclusive on all four sides.
      in_window = (sx - half_x <= px) && (px <= sx + half_x) &&
                  (sy - half_y <= py) && (py <= sy + half_y);
      hit_in = hit_ff;
      if (clear) begin
         hit_in = 1'b0;
      end else if (step && in_window) begin
         hit_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule
